// ===== hdl/tvps_pkg.sv =====
// Shared widths, constants, codes and microprogram for the pitch shifter.
package tvps_pkg;

   localparam int SampleW   = 16;
   localparam int StepW     = 20;
   localparam int GainW     = 16;
   localparam int CountW    = 2;
   localparam int CfgVoices = 3;
   localparam int VoiceW    = 2;
   localparam int CsrAddrW  = 5;
   localparam int CsrDataW  = 32;
   localparam int UcAddrW   = 5;
   localparam int WeightW   = GainW + 1;
   localparam int WetW      = 22;
   localparam int DryW      = SampleW + WeightW;
   localparam int WetProdW  = WetW + WeightW;
   localparam int MixW      = WetProdW + 1;
   localparam int MixShift  = 15;
   localparam int MixRound  = 16384;
   localparam int ClipLevel = 31130;

   localparam logic [GainW-1:0] MixBypassBelow = 16'd33;
   localparam logic [GainW-1:0] GainActiveFrom = 16'd328;
   localparam logic [GainW-1:0] UnityWeight    = 16'h8000;

   localparam logic [CountW-1:0] VoiceCountReset = 2'd3;
   localparam logic [StepW-1:0]  StepOneReset    = 20'd52012;
   localparam logic [StepW-1:0]  StepTwoReset    = 20'd43691;
   localparam logic [StepW-1:0]  StepThreeReset  = 20'd32768;
   localparam logic [GainW-1:0]  GainOneReset    = 16'd32768;
   localparam logic [GainW-1:0]  GainTwoReset    = 16'd22938;
   localparam logic [GainW-1:0]  GainThreeReset  = 16'd16384;
   localparam logic [GainW-1:0]  WetMixReset     = 16'd16384;

   typedef enum logic [2:0] {
      REG_VOICE_COUNT,
      REG_STEP_ONE,
      REG_STEP_TWO,
      REG_STEP_THREE,
      REG_GAIN_ONE,
      REG_GAIN_TWO,
      REG_GAIN_THREE,
      REG_WET_MIX
   } reg_index_type;

   typedef enum logic [UcAddrW-1:0] {
      STEP_CLEAR,
      STEP_WAIT,
      STEP_CHECK,
      STEP_WRITE,
      STEP_VOICE,
      STEP_READ1,
      STEP_DIFF,
      STEP_INTERP,
      STEP_GAIN,
      STEP_ACCUM,
      STEP_SKIP,
      STEP_MIX_DRY,
      STEP_MIX_WET,
      STEP_OUT,
      STEP_RETURN,
      STEP_BYPASS,
      STEP_BYP_RETURN
   } step_type;

   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_CLEAR,
      MEM_WRITE,
      MEM_READ0,
      MEM_READ1
   } mem_op_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_START,
      DP_LOAD_S0,
      DP_DIFF,
      DP_INTERP,
      DP_GAIN,
      DP_ACCUM,
      DP_NEXT_VOICE,
      DP_MIX_DRY,
      DP_MIX_WET,
      DP_OUT,
      DP_OUT_BYPASS
   } dp_op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_CLEAR_MORE,
      COND_NO_ITEM,
      COND_BYPASS,
      COND_VOICE_OFF,
      COND_MORE_VOICES,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      mem_op_type mem;
      dp_op_type  dp;
      cond_type   cond;
      step_type   target;
   } ucode_type;

   function automatic ucode_type uword(mem_op_type m, dp_op_type d, cond_type c,
                                       step_type t);
      ucode_type w;
      w.mem    = m;
      w.dp     = d;
      w.cond   = c;
      w.target = t;
      return w;
   endfunction

   function automatic ucode_type ucode(step_type pc);
      ucode_type w;
      unique case (pc)
         STEP_CLEAR:      w = uword(MEM_CLEAR, DP_NONE,       COND_CLEAR_MORE,  STEP_CLEAR);
         STEP_WAIT:       w = uword(MEM_NONE,  DP_START,      COND_NO_ITEM,     STEP_WAIT);
         STEP_CHECK:      w = uword(MEM_NONE,  DP_NONE,       COND_BYPASS,      STEP_BYPASS);
         STEP_WRITE:      w = uword(MEM_WRITE, DP_NONE,       COND_NEVER,       STEP_WAIT);
         STEP_VOICE:      w = uword(MEM_READ0, DP_NONE,       COND_VOICE_OFF,   STEP_SKIP);
         STEP_READ1:      w = uword(MEM_READ1, DP_LOAD_S0,    COND_NEVER,       STEP_WAIT);
         STEP_DIFF:       w = uword(MEM_NONE,  DP_DIFF,       COND_NEVER,       STEP_WAIT);
         STEP_INTERP:     w = uword(MEM_NONE,  DP_INTERP,     COND_NEVER,       STEP_WAIT);
         STEP_GAIN:       w = uword(MEM_NONE,  DP_GAIN,       COND_NEVER,       STEP_WAIT);
         STEP_ACCUM:      w = uword(MEM_NONE,  DP_ACCUM,      COND_NEVER,       STEP_WAIT);
         STEP_SKIP:       w = uword(MEM_NONE,  DP_NEXT_VOICE, COND_MORE_VOICES, STEP_VOICE);
         STEP_MIX_DRY:    w = uword(MEM_NONE,  DP_MIX_DRY,    COND_NEVER,       STEP_WAIT);
         STEP_MIX_WET:    w = uword(MEM_NONE,  DP_MIX_WET,    COND_NEVER,       STEP_WAIT);
         STEP_OUT:        w = uword(MEM_NONE,  DP_OUT,        COND_OUT_BUSY,    STEP_OUT);
         STEP_RETURN:     w = uword(MEM_NONE,  DP_NONE,       COND_ALWAYS,      STEP_WAIT);
         STEP_BYPASS:     w = uword(MEM_NONE,  DP_OUT_BYPASS, COND_OUT_BUSY,    STEP_BYPASS);
         STEP_BYP_RETURN: w = uword(MEM_NONE,  DP_NONE,       COND_ALWAYS,      STEP_WAIT);
         default:         w = uword(MEM_NONE,  DP_NONE,       COND_ALWAYS,      STEP_WAIT);
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/three_voice_delay_line_pitch_shifter.sv =====
// Microcoded three-voice delay-line pitch shifter, top level.
//
// Input channel req_* carries one signed Q1.15 sample per transfer; output
// channel rsp_* returns one mixed (or bypassed) sample per input transfer,
// in order. Registers are written through the APB port at byte address 4*i
// (voice count, three steps, three gains, wet mix); pready is always high.
// A sequencer steps through a 17-word control program; one single-port
// store read per cycle sets the pace. Each input sample is written to the
// store; each voice slot (at most three) then reads two neighbours,
// interpolates, scales by its gain and accumulates, or is skipped while
// off, and the wet sum is mixed with the dry sample. A new item is taken
// only after the last result has gone to the output register. With a wet
// mix below 33 the sample passes through. After reset the store is zeroed
// with req_ready low; registers go to their reset values. STORE_DEPTH must
// be a power of two. While the receiver stalls, the finished result waits
// in the output register and the next item is still taken and processed;
// its result is held back until the output register is free.
module three_voice_delay_line_pitch_shifter #(
   parameter int STORE_DEPTH = 4096,
   parameter int VOICES      = 3,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [tvps_pkg::SampleW-1:0] req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tvps_pkg::SampleW-1:0] rsp_sample_out,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tvps_pkg::CsrAddrW-1:0]       paddr,
   input  logic [tvps_pkg::CsrDataW-1:0]       pwdata,
   output logic [tvps_pkg::CsrDataW-1:0]       prdata,
   output logic                                pready
);

   localparam int AddrW       = $clog2(STORE_DEPTH);
   localparam int PosW        = AddrW + FRAC_BITS;
   localparam int SumW        = ((PosW > tvps_pkg::StepW) ? PosW : tvps_pkg::StepW) + 1;
   localparam int RunVoices   = (VOICES < tvps_pkg::CfgVoices) ? VOICES : tvps_pkg::CfgVoices;
   localparam int FracWtW     = FRAC_BITS + 1;
   localparam int InterpW     = tvps_pkg::SampleW + FRAC_BITS + 2;
   localparam int GainProdW   = InterpW + tvps_pkg::WeightW;
   localparam int AccW        = GainProdW + 2;
   localparam int WetShift    = FRAC_BITS + 15;
   localparam int WetRoundBit = FRAC_BITS + 14;
   localparam logic signed [AccW-1:0] WetRound = AccW'(1) << WetRoundBit;

   tvps_pkg::step_type  pc_ff, pc_in;
   tvps_pkg::ucode_type uw;
   logic [tvps_pkg::UcAddrW-1:0] pc_seq;
   logic                         taken;

   logic [AddrW-1:0]                  wp_ff;
   logic [PosW-1:0]                   pos_ff [RunVoices];
   logic [tvps_pkg::VoiceW-1:0]       vidx_ff;
   logic [tvps_pkg::CountW-1:0]       voice_count_ff;
   logic [tvps_pkg::StepW-1:0]        step_ff [tvps_pkg::CfgVoices];
   logic [tvps_pkg::GainW-1:0]        gain_ff [tvps_pkg::CfgVoices];
   logic [tvps_pkg::GainW-1:0]        wet_mix_ff;
   logic                              rsp_valid_ff;
   logic signed [tvps_pkg::SampleW-1:0] rsp_sample_out_ff;

   logic [tvps_pkg::SampleW-1:0]        store [STORE_DEPTH];
   logic [tvps_pkg::SampleW-1:0]        rdata_ff;
   logic signed [tvps_pkg::SampleW-1:0] x_ff;
   logic signed [tvps_pkg::SampleW-1:0] s0_ff;
   logic signed [InterpW-1:0]           diff_prod_ff;
   logic signed [InterpW-1:0]           interp_ff;
   logic signed [GainProdW-1:0]         gain_prod_ff;
   logic signed [AccW-1:0]              acc_ff;
   logic signed [tvps_pkg::WetW-1:0]    wet_ff;
   logic signed [tvps_pkg::DryW-1:0]    dry_ff;
   logic signed [tvps_pkg::WetProdW-1:0] wet_prod_ff;

   logic                           accept;
   logic                           out_free;
   logic                           bypass;
   logic                           voice_on;
   logic                           csr_write;
   tvps_pkg::reg_index_type        csr_index;
   logic [PosW-1:0]                cur_pos;
   logic [tvps_pkg::StepW-1:0]     cur_step;
   logic [tvps_pkg::GainW-1:0]     cur_gain;
   logic [AddrW-1:0]               i0, i1;
   logic [FRAC_BITS-1:0]           frac;
   logic [SumW-1:0]                pos_sum;
   logic [PosW-1:0]                pos_next;
   logic                           mem_we;
   logic [AddrW-1:0]               mem_addr;
   logic [tvps_pkg::SampleW-1:0]   mem_wdata;

   logic signed [tvps_pkg::SampleW-1:0]  s1;
   logic signed [tvps_pkg::SampleW:0]    diff;
   logic signed [FracWtW-1:0]            frac_wt;
   logic signed [tvps_pkg::WeightW-1:0]  gain_wt;
   logic signed [tvps_pkg::WeightW-1:0]  dry_wt;
   logic signed [tvps_pkg::WeightW-1:0]  mix_wt;
   logic signed [InterpW-1:0]            diff_prod_in;
   logic signed [InterpW-1:0]            interp_in;
   logic signed [GainProdW-1:0]          gain_prod_in;
   logic signed [AccW-1:0]               acc_in;
   logic signed [AccW-1:0]               acc_round;
   logic signed [AccW-1:0]               acc_shift;
   logic signed [tvps_pkg::WetW-1:0]     wet_in;
   logic signed [tvps_pkg::DryW-1:0]     dry_in;
   logic signed [tvps_pkg::WetProdW-1:0] wet_prod_in;
   logic signed [tvps_pkg::MixW-1:0]     mix_sum;
   logic signed [tvps_pkg::MixW-1:0]     mix_shift;
   logic signed [tvps_pkg::SampleW-1:0]  sample_out_in;

   assign uw        = tvps_pkg::ucode(pc_ff);
   assign req_ready = (pc_ff == tvps_pkg::STEP_WAIT);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign bypass    = (wet_mix_ff < tvps_pkg::MixBypassBelow);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = tvps_pkg::reg_index_type'(paddr[4:2]);

   always_comb begin
      cur_pos = '0;
      for (int v = 0; v < RunVoices; v++) begin
         if (vidx_ff == tvps_pkg::VoiceW'(v)) begin
            cur_pos = pos_ff[v];
         end
      end
   end

   assign cur_step = step_ff[vidx_ff];
   assign cur_gain = gain_ff[vidx_ff];
   assign i0       = cur_pos[PosW-1:FRAC_BITS];
   assign i1       = i0 + AddrW'(1);
   assign frac     = cur_pos[FRAC_BITS-1:0];
   assign voice_on = (vidx_ff < voice_count_ff) && (cur_gain >= tvps_pkg::GainActiveFrom);
   assign pos_sum  = SumW'(cur_pos) + SumW'(cur_step);
   assign pos_next = pos_sum[PosW-1:0];

   always_comb begin
      unique case (uw.cond)
         tvps_pkg::COND_NEVER:       taken = 1'b0;
         tvps_pkg::COND_ALWAYS:      taken = 1'b1;
         tvps_pkg::COND_CLEAR_MORE:  taken = (wp_ff != '1);
         tvps_pkg::COND_NO_ITEM:     taken = !req_valid;
         tvps_pkg::COND_BYPASS:      taken = bypass;
         tvps_pkg::COND_VOICE_OFF:   taken = !voice_on;
         tvps_pkg::COND_MORE_VOICES: taken = (vidx_ff != tvps_pkg::VoiceW'(RunVoices - 1));
         tvps_pkg::COND_OUT_BUSY:    taken = !out_free;
         default:                    taken = 1'b0;
      endcase
   end

   assign pc_seq = pc_ff + tvps_pkg::UcAddrW'(1);
   assign pc_in  = taken ? uw.target : tvps_pkg::step_type'(pc_seq);

   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = wp_ff;
      mem_wdata = x_ff;
      case (uw.mem)
         tvps_pkg::MEM_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
         end
         tvps_pkg::MEM_WRITE: mem_we = 1'b1;
         tvps_pkg::MEM_READ0: mem_addr = i0;
         tvps_pkg::MEM_READ1: mem_addr = i1;
         default:             mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_addr] <= mem_wdata;
      end
      rdata_ff <= store[mem_addr];
   end

   assign s1           = signed'(rdata_ff);
   assign diff         = (tvps_pkg::SampleW + 1)'(s1) - (tvps_pkg::SampleW + 1)'(s0_ff);
   assign frac_wt      = signed'({1'b0, frac});
   assign diff_prod_in = InterpW'(diff) * InterpW'(frac_wt);
   assign interp_in    = (InterpW'(s0_ff) <<< FRAC_BITS) + diff_prod_ff;
   assign gain_wt      = signed'({1'b0, cur_gain});
   assign gain_prod_in = GainProdW'(interp_ff) * GainProdW'(gain_wt);
   assign acc_in       = acc_ff + AccW'(gain_prod_ff);
   assign acc_round    = acc_ff + WetRound;
   assign acc_shift    = acc_round >>> WetShift;
   assign wet_in       = acc_shift[tvps_pkg::WetW-1:0];
   assign dry_wt       = signed'({1'b0, tvps_pkg::UnityWeight} - {1'b0, wet_mix_ff});
   assign mix_wt       = signed'({1'b0, wet_mix_ff});
   assign dry_in       = tvps_pkg::DryW'(x_ff) * tvps_pkg::DryW'(dry_wt);
   assign wet_prod_in  = tvps_pkg::WetProdW'(wet_ff) * tvps_pkg::WetProdW'(mix_wt);
   assign mix_sum      = tvps_pkg::MixW'(dry_ff) + tvps_pkg::MixW'(wet_prod_ff)
                         + tvps_pkg::MixW'(tvps_pkg::MixRound);
   assign mix_shift    = mix_sum >>> tvps_pkg::MixShift;

   always_comb begin
      if (mix_shift > tvps_pkg::MixW'(tvps_pkg::ClipLevel)) begin
         sample_out_in = tvps_pkg::SampleW'(tvps_pkg::ClipLevel);
      end else if (mix_shift < tvps_pkg::MixW'(-tvps_pkg::ClipLevel)) begin
         sample_out_in = tvps_pkg::SampleW'(-tvps_pkg::ClipLevel);
      end else begin
         sample_out_in = mix_shift[tvps_pkg::SampleW-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         tvps_pkg::REG_VOICE_COUNT: prdata = tvps_pkg::CsrDataW'(voice_count_ff);
         tvps_pkg::REG_STEP_ONE:    prdata = tvps_pkg::CsrDataW'(step_ff[0]);
         tvps_pkg::REG_STEP_TWO:    prdata = tvps_pkg::CsrDataW'(step_ff[1]);
         tvps_pkg::REG_STEP_THREE:  prdata = tvps_pkg::CsrDataW'(step_ff[2]);
         tvps_pkg::REG_GAIN_ONE:    prdata = tvps_pkg::CsrDataW'(gain_ff[0]);
         tvps_pkg::REG_GAIN_TWO:    prdata = tvps_pkg::CsrDataW'(gain_ff[1]);
         tvps_pkg::REG_GAIN_THREE:  prdata = tvps_pkg::CsrDataW'(gain_ff[2]);
         tvps_pkg::REG_WET_MIX:     prdata = tvps_pkg::CsrDataW'(wet_mix_ff);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff          <= tvps_pkg::STEP_CLEAR;
         wp_ff          <= '0;
         vidx_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         voice_count_ff <= tvps_pkg::VoiceCountReset;
         step_ff[0]     <= tvps_pkg::StepOneReset;
         step_ff[1]     <= tvps_pkg::StepTwoReset;
         step_ff[2]     <= tvps_pkg::StepThreeReset;
         gain_ff[0]     <= tvps_pkg::GainOneReset;
         gain_ff[1]     <= tvps_pkg::GainTwoReset;
         gain_ff[2]     <= tvps_pkg::GainThreeReset;
         wet_mix_ff     <= tvps_pkg::WetMixReset;
         for (int v = 0; v < RunVoices; v++) begin
            pos_ff[v] <= '0;
         end
      end else begin
         pc_ff <= pc_in;
         if (mem_we) begin
            wp_ff <= wp_ff + AddrW'(1);
         end
         case (uw.dp)
            tvps_pkg::DP_START:      vidx_ff <= '0;
            tvps_pkg::DP_NEXT_VOICE: vidx_ff <= vidx_ff + tvps_pkg::VoiceW'(1);
            tvps_pkg::DP_GAIN: begin
               for (int v = 0; v < RunVoices; v++) begin
                  if (vidx_ff == tvps_pkg::VoiceW'(v)) begin
                     pos_ff[v] <= pos_next;
                  end
               end
            end
            default: vidx_ff <= vidx_ff;
         endcase
         if ((uw.dp == tvps_pkg::DP_OUT || uw.dp == tvps_pkg::DP_OUT_BYPASS) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            unique case (csr_index)
               tvps_pkg::REG_VOICE_COUNT: voice_count_ff <= pwdata[tvps_pkg::CountW-1:0];
               tvps_pkg::REG_STEP_ONE:    step_ff[0] <= pwdata[tvps_pkg::StepW-1:0];
               tvps_pkg::REG_STEP_TWO:    step_ff[1] <= pwdata[tvps_pkg::StepW-1:0];
               tvps_pkg::REG_STEP_THREE:  step_ff[2] <= pwdata[tvps_pkg::StepW-1:0];
               tvps_pkg::REG_GAIN_ONE:    gain_ff[0] <= pwdata[tvps_pkg::GainW-1:0];
               tvps_pkg::REG_GAIN_TWO:    gain_ff[1] <= pwdata[tvps_pkg::GainW-1:0];
               tvps_pkg::REG_GAIN_THREE:  gain_ff[2] <= pwdata[tvps_pkg::GainW-1:0];
               tvps_pkg::REG_WET_MIX:     wet_mix_ff <= pwdata[tvps_pkg::GainW-1:0];
               default:                   wet_mix_ff <= wet_mix_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= req_sample_in;
      end
      case (uw.dp)
         tvps_pkg::DP_START:    acc_ff <= '0;
         tvps_pkg::DP_LOAD_S0:  s0_ff <= signed'(rdata_ff);
         tvps_pkg::DP_DIFF:     diff_prod_ff <= diff_prod_in;
         tvps_pkg::DP_INTERP:   interp_ff <= interp_in;
         tvps_pkg::DP_GAIN:     gain_prod_ff <= gain_prod_in;
         tvps_pkg::DP_ACCUM:    acc_ff <= acc_in;
         tvps_pkg::DP_MIX_DRY: begin
            wet_ff <= wet_in;
            dry_ff <= dry_in;
         end
         tvps_pkg::DP_MIX_WET:  wet_prod_ff <= wet_prod_in;
         tvps_pkg::DP_OUT: begin
            if (out_free) begin
               rsp_sample_out_ff <= sample_out_in;
            end
         end
         tvps_pkg::DP_OUT_BYPASS: begin
            if (out_free) begin
               rsp_sample_out_ff <= x_ff;
            end
         end
         default: acc_ff <= acc_ff;
      endcase
   end

endmodule

// ===== hdl/tvps_checker.sv =====
// Port-level checks for the pitch shifter, bound to the top level.
module tvps_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [tvps_pkg::SampleW-1:0] rsp_sample_out,
   input logic                                pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("result changed or dropped while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in progress");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_ready)
      else $error("channels active right after reset");

   a_pready_high: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("register port not ready");

endmodule

bind three_voice_delay_line_pitch_shifter tvps_checker u_tvps_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the three-voice delay-line pitch shifter.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StoreDepth   = 4096;
   localparam int FracBits     = 16;
   localparam int PosW         = 28;
   localparam int SettleCycles = 30;
   localparam int StallLimit   = 20000;
   localparam int BlockItems   = 70;
   localparam int BlocksPerPhase = 5;

   typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      tvps_pkg::reg_index_type target;
      logic signed [31:0]      value;
      logic                    known;
      logic signed [15:0]      expected;
   } stim_row_type;

   localparam int DirectedRows = 42;
   localparam stim_row_type DirectedTable [DirectedRows] = '{
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, 32767,   1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, -32768,  1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, 0,       1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, 1,       1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, -1,      1'b0, 16'sd0},
      '{ROW_WRITE, tvps_pkg::REG_WET_MIX,     0,       1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, 32767,   1'b1, 16'sd32767},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, -32768,  1'b1, -16'sd32768},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, 21845,   1'b1, 16'sd21845},
      '{ROW_WRITE, tvps_pkg::REG_WET_MIX,     32,      1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, -21846,  1'b1, -16'sd21846},
      '{ROW_WRITE, tvps_pkg::REG_WET_MIX,     33,      1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, 100,     1'b0, 16'sd0},
      '{ROW_WRITE, tvps_pkg::REG_VOICE_COUNT, 0,       1'b0, 16'sd0},
      '{ROW_WRITE, tvps_pkg::REG_WET_MIX,     16384,   1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, 32767,   1'b1, 16'sd16384},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, -32768,  1'b1, -16'sd16384},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, 3,       1'b1, 16'sd2},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, -3,      1'b1, -16'sd1},
      '{ROW_WRITE, tvps_pkg::REG_WET_MIX,     32768,   1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, 20000,   1'b1, 16'sd0},
      '{ROW_WRITE, tvps_pkg::REG_VOICE_COUNT, 3,       1'b0, 16'sd0},
      '{ROW_WRITE, tvps_pkg::REG_GAIN_ONE,    327,     1'b0, 16'sd0},
      '{ROW_WRITE, tvps_pkg::REG_GAIN_TWO,    328,     1'b0, 16'sd0},
      '{ROW_WRITE, tvps_pkg::REG_GAIN_THREE,  65535,   1'b0, 16'sd0},
      '{ROW_WRITE, tvps_pkg::REG_STEP_ONE,    0,       1'b0, 16'sd0},
      '{ROW_WRITE, tvps_pkg::REG_STEP_TWO,    1048575, 1'b0, 16'sd0},
      '{ROW_WRITE, tvps_pkg::REG_STEP_THREE,  65536,   1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, 32767,   1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, -32768,  1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, 5000,    1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, -7,      1'b0, 16'sd0},
      '{ROW_WRITE, tvps_pkg::REG_VOICE_COUNT, 1,       1'b0, 16'sd0},
      '{ROW_WRITE, tvps_pkg::REG_GAIN_ONE,    32768,   1'b0, 16'sd0},
      '{ROW_WRITE, tvps_pkg::REG_WET_MIX,     65535,   1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, 32767,   1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, -32768,  1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, 9,       1'b0, 16'sd0},
      '{ROW_WRITE, tvps_pkg::REG_VOICE_COUNT, 2,       1'b0, 16'sd0},
      '{ROW_WRITE, tvps_pkg::REG_STEP_ONE,    1048575, 1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, 32767,   1'b0, 16'sd0},
      '{ROW_ITEM,  tvps_pkg::REG_VOICE_COUNT, -12345,  1'b0, 16'sd0}
   };

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic signed [tvps_pkg::SampleW-1:0] req_sample_in;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic signed [tvps_pkg::SampleW-1:0] rsp_sample_out;
   logic                                psel;
   logic                                penable;
   logic                                pwrite;
   logic [tvps_pkg::CsrAddrW-1:0]       paddr;
   logic [tvps_pkg::CsrDataW-1:0]       pwdata;
   logic [tvps_pkg::CsrDataW-1:0]       prdata;
   logic                                pready;

   logic signed [tvps_pkg::SampleW-1:0] voice_store [StoreDepth];
   logic [PosW-FracBits-1:0]            write_ptr;
   logic [PosW-1:0]                     read_pos [tvps_pkg::CfgVoices];
   logic [tvps_pkg::CountW-1:0]         voice_count_q;
   logic [tvps_pkg::StepW-1:0]          step_q [tvps_pkg::CfgVoices];
   logic [tvps_pkg::GainW-1:0]          gain_q [tvps_pkg::CfgVoices];
   logic [tvps_pkg::GainW-1:0]          wet_mix_q;

   logic signed [tvps_pkg::SampleW-1:0] expected_samples [$];
   bit                         sent_since_idle;
   int                         send_idle_pct;
   int                         recv_idle_pct;
   int                         fail_count;
   int                         sent_count;
   int                         checked_count;
   int                         write_count;
   int                         bypass_count;
   int                         clip_count;
   int                         idle_cycles;

   three_voice_delay_line_pitch_shifter DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [tvps_pkg::SampleW-1:0] shift_sample(
      input logic signed [tvps_pkg::SampleW-1:0] x);
      logic [PosW-FracBits-1:0] idx0;
      longint s0, s1, frac, acc, wet, mixed;
      acc = 0;
      if (wet_mix_q < tvps_pkg::MixBypassBelow) begin
         bypass_count++;
         return x;
      end
      voice_store[write_ptr] = x;
      write_ptr = write_ptr + 1'b1;
      for (int v = 0; v < tvps_pkg::CfgVoices; v++) begin
         if (v < voice_count_q && gain_q[v] >= tvps_pkg::GainActiveFrom) begin
            idx0 = read_pos[v][PosW-1:FracBits];
            frac = read_pos[v][FracBits-1:0];
            s0 = voice_store[idx0];
            s1 = voice_store[(PosW-FracBits)'(idx0 + 1'b1)];
            acc += (s0 * ((longint'(1) <<< FracBits) - frac) + s1 * frac)
                   * longint'(gain_q[v]);
            read_pos[v] = read_pos[v] + step_q[v];
         end
      end
      wet = (acc + (longint'(1) <<< (FracBits + 14))) >>> (FracBits + 15);
      mixed = (longint'(x) * (32768 - longint'(wet_mix_q))
               + wet * longint'(wet_mix_q) + tvps_pkg::MixRound) >>> tvps_pkg::MixShift;
      if (mixed > tvps_pkg::ClipLevel) begin
         mixed = tvps_pkg::ClipLevel;
         clip_count++;
      end else if (mixed < -tvps_pkg::ClipLevel) begin
         mixed = -tvps_pkg::ClipLevel;
         clip_count++;
      end
      return mixed[tvps_pkg::SampleW-1:0];
   endfunction

   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      sent_since_idle = 1'b0;
   endtask

   task automatic write_csr(input tvps_pkg::reg_index_type target,
                            input logic [tvps_pkg::CsrDataW-1:0] value);
      if (sent_since_idle) settle_block();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {target, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (target)
         tvps_pkg::REG_VOICE_COUNT: voice_count_q = value[tvps_pkg::CountW-1:0];
         tvps_pkg::REG_STEP_ONE:    step_q[0] = value[tvps_pkg::StepW-1:0];
         tvps_pkg::REG_STEP_TWO:    step_q[1] = value[tvps_pkg::StepW-1:0];
         tvps_pkg::REG_STEP_THREE:  step_q[2] = value[tvps_pkg::StepW-1:0];
         tvps_pkg::REG_GAIN_ONE:    gain_q[0] = value[tvps_pkg::GainW-1:0];
         tvps_pkg::REG_GAIN_TWO:    gain_q[1] = value[tvps_pkg::GainW-1:0];
         tvps_pkg::REG_GAIN_THREE:  gain_q[2] = value[tvps_pkg::GainW-1:0];
         default:                   wet_mix_q = value[tvps_pkg::GainW-1:0];
      endcase
      write_count++;
      @(posedge clock);
   endtask

   task automatic send_sample(input logic signed [tvps_pkg::SampleW-1:0] s,
                              input logic known,
                              input logic signed [tvps_pkg::SampleW-1:0] typed);
      logic signed [tvps_pkg::SampleW-1:0] predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = shift_sample(s);
      expected_samples.push_back(known ? typed : predicted);
      sent_since_idle = 1'b1;
      sent_count++;
   endtask

   task automatic pick_settings();
      logic [tvps_pkg::CsrDataW-1:0] value;
      value = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
      write_csr(tvps_pkg::REG_VOICE_COUNT, value);
      for (int v = 0; v < tvps_pkg::CfgVoices; v++) begin
         case ($urandom_range(7))
            0:       value = 0;
            1:       value = 20'hFFFFF;
            2:       value = 65536;
            3, 4:    value = $urandom_range(1, 131071);
            default: value = $urandom_range(0, 20'hFFFFF);
         endcase
         write_csr(tvps_pkg::reg_index_type'(tvps_pkg::REG_STEP_ONE + v), value);
         case ($urandom_range(9))
            0:       value = 0;
            1:       value = tvps_pkg::GainActiveFrom - 1;
            2:       value = tvps_pkg::GainActiveFrom;
            3:       value = tvps_pkg::UnityWeight;
            4:       value = 16'hFFFF;
            default: value = $urandom_range(tvps_pkg::GainActiveFrom, tvps_pkg::UnityWeight);
         endcase
         write_csr(tvps_pkg::reg_index_type'(tvps_pkg::REG_GAIN_ONE + v), value);
      end
      case ($urandom_range(11))
         0:       value = $urandom_range(0, tvps_pkg::MixBypassBelow - 1);
         1:       value = tvps_pkg::MixBypassBelow;
         2:       value = tvps_pkg::UnityWeight;
         3:       value = 16'hFFFF;
         4:       value = $urandom_range(tvps_pkg::UnityWeight + 1, 16'hFFFF);
         default: value = $urandom_range(tvps_pkg::MixBypassBelow, tvps_pkg::UnityWeight);
      endcase
      write_csr(tvps_pkg::REG_WET_MIX, value);
   endtask

   // receiver: check each transfer, then pick the next ready
   initial begin
      logic signed [tvps_pkg::SampleW-1:0] want;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $error("sample_out: no result expected, actual %0d", rsp_sample_out);
               fail_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample_out !== want) begin
                  $error("sample_out: expected %0d, actual %0d", want, rsp_sample_out);
                  fail_count++;
               end
               checked_count++;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < StallLimit) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid === 1'b1 && rsp_ready) || psel)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $error("no transfer for %0d cycles", StallLimit);
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      logic signed [tvps_pkg::SampleW-1:0] s;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_sample_in = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      for (int i = 0; i < StoreDepth; i++) voice_store[i] = '0;
      write_ptr     = '0;
      for (int v = 0; v < tvps_pkg::CfgVoices; v++) read_pos[v] = '0;
      voice_count_q = tvps_pkg::VoiceCountReset;
      step_q[0]     = tvps_pkg::StepOneReset;
      step_q[1]     = tvps_pkg::StepTwoReset;
      step_q[2]     = tvps_pkg::StepThreeReset;
      gain_q[0]     = tvps_pkg::GainOneReset;
      gain_q[1]     = tvps_pkg::GainTwoReset;
      gain_q[2]     = tvps_pkg::GainThreeReset;
      wet_mix_q     = tvps_pkg::WetMixReset;
      send_idle_pct = 10;
      recv_idle_pct = 77;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DirectedTable[i]) begin
         if (DirectedTable[i].kind == ROW_WRITE)
            write_csr(DirectedTable[i].target, DirectedTable[i].value);
         else
            send_sample(DirectedTable[i].value[tvps_pkg::SampleW-1:0],
                        DirectedTable[i].known, DirectedTable[i].expected);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 10;
               recv_idle_pct = 77;
            end
            1: begin
               send_idle_pct = 77;
               recv_idle_pct = 10;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int blk = 0; blk < BlocksPerPhase; blk++) begin
            pick_settings();
            for (int n = 0; n < BlockItems; n++) begin
               case ($urandom_range(15))
                  0:       s = 16'sh7FFF;
                  1:       s = 16'sh8000;
                  2:       s = tvps_pkg::SampleW'(int'($urandom_range(64)) - 32);
                  default: s = tvps_pkg::SampleW'($urandom);
               endcase
               send_sample(s, 1'b0, '0);
            end
         end
      end

      settle_block();
      $display("tb: %0d samples sent, %0d results checked, %0d register writes",
               sent_count, checked_count, write_count);
      $display("tb: %0d samples bypassed, %0d results clipped", bypass_count, clip_count);
      if (fail_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/tvps_pkg.sv
hdl/three_voice_delay_line_pitch_shifter.sv
hdl/tvps_checker.sv
tb/sv/tb.sv
